FILE: rtl/b64se_pkg.sv
// package for the base64 stream encoder
// holds the character table function, the phase type and the job word between front and back
// no dependencies
package b64se_pkg;

   localparam int CharWidth = 7;
   localparam int JobChars  = 4;
   localparam int QueueDepth = 2;

   localparam logic [CharWidth-1:0] PadChar = 7'h3D;

   typedef enum logic [1:0] {
      PHASE_0 = 2'd0,
      PHASE_1 = 2'd1,
      PHASE_2 = 2'd2
   } phase_type;

   typedef struct packed {
      logic [JobChars-1:0][CharWidth-1:0] chars;
      logic [1:0]                         last_idx;
      logic                               msg_last;
   } job_type;

   function automatic logic [CharWidth-1:0] sym(input logic [5:0] idx);
      logic [CharWidth-1:0] ch;
      if (idx < 6'd26) begin
         ch = 7'h41 + {1'b0, idx};
      end else if (idx < 6'd52) begin
         ch = 7'h61 + {1'b0, idx - 6'd26};
      end else if (idx < 6'd62) begin
         ch = 7'h30 + {1'b0, idx - 6'd52};
      end else if (idx == 6'd62) begin
         ch = 7'h2B;
      end else begin
         ch = 7'h2F;
      end
      return ch;
   endfunction

endpackage

FILE: rtl/b64se_front.sv
// front part of the base64 stream encoder: group phase and leftover bits,
// turns each accepted byte into a job of one to four characters
// depends on b64se_pkg
module b64se_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        data_byte,
   input  logic              final_byte,
   output b64se_pkg::job_type job
);

   b64se_pkg::phase_type phase_ff, phase_in;
   logic [3:0]           left_ff, left_in;

   always_comb begin
      job       = '0;
      phase_in  = phase_ff;
      left_in   = left_ff;
      job.msg_last = final_byte;
      unique case (phase_ff)
         b64se_pkg::PHASE_1: begin
            job.chars[0] = b64se_pkg::sym({left_ff[1:0], data_byte[7:4]});
            if (final_byte) begin
               job.chars[1] = b64se_pkg::sym({data_byte[3:0], 2'b00});
               job.chars[2] = b64se_pkg::PadChar;
               job.last_idx = 2'd2;
               phase_in     = b64se_pkg::PHASE_0;
               left_in      = 4'd0;
            end else begin
               job.last_idx = 2'd0;
               phase_in     = b64se_pkg::PHASE_2;
               left_in      = data_byte[3:0];
            end
         end
         b64se_pkg::PHASE_2: begin
            job.chars[0] = b64se_pkg::sym({left_ff, data_byte[7:6]});
            job.chars[1] = b64se_pkg::sym(data_byte[5:0]);
            job.last_idx = 2'd1;
            phase_in     = b64se_pkg::PHASE_0;
            left_in      = 4'd0;
         end
         default: begin
            job.chars[0] = b64se_pkg::sym(data_byte[7:2]);
            if (final_byte) begin
               job.chars[1] = b64se_pkg::sym({data_byte[1:0], 4'b0000});
               job.chars[2] = b64se_pkg::PadChar;
               job.chars[3] = b64se_pkg::PadChar;
               job.last_idx = 2'd3;
               phase_in     = b64se_pkg::PHASE_0;
               left_in      = 4'd0;
            end else begin
               job.last_idx = 2'd0;
               phase_in     = b64se_pkg::PHASE_1;
               left_in      = {2'b00, data_byte[1:0]};
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= b64se_pkg::PHASE_0;
         left_ff  <= 4'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         left_ff  <= left_in;
      end
   end

endmodule

FILE: rtl/b64se_queue.sv
// short job queue between front and back of the base64 stream encoder
// depends on b64se_pkg
module b64se_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  b64se_pkg::job_type wr_job,
   output logic              full,
   input  logic              rd_en,
   output logic              rd_valid,
   output b64se_pkg::job_type rd_job
);

   localparam int PtrWidth = $clog2(b64se_pkg::QueueDepth);
   localparam int CntWidth = $clog2(b64se_pkg::QueueDepth + 1);

   b64se_pkg::job_type         mem [b64se_pkg::QueueDepth];
   logic [PtrWidth-1:0]        wr_ptr_ff, rd_ptr_ff;
   logic [CntWidth-1:0]        count_ff, count_in;

   assign full     = (count_ff == CntWidth'(b64se_pkg::QueueDepth));
   assign rd_valid = (count_ff != '0);
   assign rd_job   = mem[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (!wr_en && rd_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_ptr_ff] <= wr_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (wr_en) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrWidth'(b64se_pkg::QueueDepth - 1)) ? '0
                                                                            : wr_ptr_ff + 1'b1;
         end
         if (rd_en) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrWidth'(b64se_pkg::QueueDepth - 1)) ? '0
                                                                            : rd_ptr_ff + 1'b1;
         end
      end
   end

endmodule

FILE: rtl/b64se_back.sv
// back part of the base64 stream encoder: steps through the characters
// of the head job into the result register, one per cycle while it is
// free or popped; depends on b64se_pkg
module b64se_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              job_valid,
   input  b64se_pkg::job_type                job,
   output logic                              job_done,
   output logic                              empty,
   input  logic                              pop,
   output logic [b64se_pkg::CharWidth-1:0]   code_char,
   output logic                              run_end,
   output logic                              message_end
);

   logic [1:0]                        sel_ff, sel_in;
   logic                              valid_ff, valid_in;
   logic [b64se_pkg::CharWidth-1:0]   char_ff;
   logic                              run_end_ff, msg_end_ff;
   logic                              load, at_last;

   assign at_last  = (sel_ff == job.last_idx);
   assign load     = job_valid && (!valid_ff || pop);
   assign job_done = load && at_last;

   always_comb begin
      sel_in   = sel_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         sel_in   = at_last ? 2'd0 : sel_ff + 2'd1;
      end else if (pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         sel_ff   <= sel_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         char_ff    <= job.chars[sel_ff];
         run_end_ff <= at_last;
         msg_end_ff <= at_last && job.msg_last;
      end
   end

   assign empty       = !valid_ff;
   assign code_char   = char_ff;
   assign run_end     = run_end_ff;
   assign message_end = msg_end_ff;

endmodule

FILE: rtl/base64_stream_encoder.sv
// Base64 stream encoder, standard alphabet with '=' padding. Bytes enter one
// per word; the final byte of a message closes it with any partial character
// and padding. Output is one character per cycle from the result register
// while pop keeps it free; a byte yields one to four characters, and the
// character stepper in the back part sets that output pace.
// A two-job queue lets bytes be taken while earlier characters are still
// going out. With the result side idle, the first character of a byte goes
// through the job queue and then the result register to the result ports.
// depends on b64se_pkg, b64se_front, b64se_queue, b64se_back
module base64_stream_encoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_data_byte,
   input  logic        req_final_byte,
   output logic        empty,
   input  logic        pop,
   output logic [6:0]  rsp_code_char,
   output logic        rsp_run_end,
   output logic        rsp_message_end
);

   b64se_pkg::job_type new_job, head_job;
   logic               accept, head_valid, head_done;

   assign accept = push && !full;

   b64se_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .data_byte  (req_data_byte),
      .final_byte (req_final_byte),
      .job        (new_job)
   );

   b64se_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (accept),
      .wr_job   (new_job),
      .full     (full),
      .rd_en    (head_done),
      .rd_valid (head_valid),
      .rd_job   (head_job)
   );

   b64se_back u_back (
      .clock       (clock),
      .reset       (reset),
      .job_valid   (head_valid),
      .job         (head_job),
      .job_done    (head_done),
      .empty       (empty),
      .pop         (pop),
      .code_char   (rsp_code_char),
      .run_end     (rsp_run_end),
      .message_end (rsp_message_end)
   );

endmodule

FILE: dv/tb_base64_stream_encoder.sv
`timescale 1ns / 1ps
// testbench for base64_stream_encoder: sends byte messages, predicts the character stream
// and checks every popped word against it; depends on b64se_pkg and the encoder rtl
module tb_base64_stream_encoder;

   localparam int ClockPeriod = 8;
   localparam int ResetCycles = 7;
   localparam int StallLimit = 5000;
   localparam int DrainCycles = 16;
   localparam int MaxReports = 10;
   localparam logic [64*8-1:0] Alphabet =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   typedef struct packed {
      logic [6:0] code;
      logic       run_end;
      logic       msg_end;
   } code_word_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       push = 1'b0;
   logic       full;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_final_byte = 1'b0;
   logic       empty;
   logic       pop = 1'b0;
   logic [6:0] rsp_code_char;
   logic       rsp_run_end;
   logic       rsp_message_end;

   code_word_type        expected_chars[$];
   logic [3:0]           leftover = 4'h0;
   b64se_pkg::phase_type group_phase = b64se_pkg::PHASE_0;
   int                   send_gap_pct = 0;
   int                   recv_gap_pct = 0;
   int                   mismatches = 0;
   int                   quiet_cycles = 0;

   base64_stream_encoder u_dut (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_data_byte   (req_data_byte),
      .req_final_byte  (req_final_byte),
      .empty           (empty),
      .pop             (pop),
      .rsp_code_char   (rsp_code_char),
      .rsp_run_end     (rsp_run_end),
      .rsp_message_end (rsp_message_end)
   );

   always #(ClockPeriod / 2) clock = ~clock;

   function automatic logic [6:0] b64_char(input logic [5:0] idx);
      logic [7:0] ch;
      ch = Alphabet[(63 - idx) * 8 +: 8];
      return ch[6:0];
   endfunction

   function automatic void encode_byte(input logic [7:0] data, input logic fin);
      logic [6:0]    chars [0:3];
      int            n;
      int            i;
      code_word_type word;
      n = 0;
      case (group_phase)
         b64se_pkg::PHASE_1: begin
            chars[0] = b64_char({leftover[1:0], data[7:4]});
            n = 1;
            leftover = data[3:0];
            group_phase = b64se_pkg::PHASE_2;
         end
         b64se_pkg::PHASE_2: begin
            chars[0] = b64_char({leftover, data[7:6]});
            chars[1] = b64_char(data[5:0]);
            n = 2;
            leftover = 4'h0;
            group_phase = b64se_pkg::PHASE_0;
         end
         default: begin
            chars[0] = b64_char(data[7:2]);
            n = 1;
            leftover = {2'b00, data[1:0]};
            group_phase = b64se_pkg::PHASE_1;
         end
      endcase
      if (fin) begin
         if (group_phase == b64se_pkg::PHASE_1) begin
            chars[n] = b64_char({leftover[1:0], 4'h0});
            chars[n + 1] = b64se_pkg::PadChar;
            chars[n + 2] = b64se_pkg::PadChar;
            n = n + 3;
         end else if (group_phase == b64se_pkg::PHASE_2) begin
            chars[n] = b64_char({leftover, 2'b00});
            chars[n + 1] = b64se_pkg::PadChar;
            n = n + 2;
         end
         leftover = 4'h0;
         group_phase = b64se_pkg::PHASE_0;
      end
      for (i = 0; i < n; i++) begin
         word.code = chars[i];
         word.run_end = (i == n - 1);
         word.msg_end = (fin && i == n - 1);
         expected_chars = {expected_chars, word};
      end
   endfunction

   task automatic send_byte(input logic [7:0] data, input logic fin);
      while ($urandom_range(99) < send_gap_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_data_byte <= data;
      req_final_byte <= fin;
      @(posedge clock);
      while (full) @(posedge clock);
      encode_byte(data, fin);
   endtask

   task automatic send_message(input logic [7:0] bytes[$]);
      int i;
      for (i = 0; i < bytes.size(); i++) begin
         send_byte(bytes[i], i == bytes.size() - 1);
      end
   endtask

   // every group phase at the end of a message, extremes and the last two symbols
   task automatic test_padding_cases();
      send_message('{8'h00});
      send_message('{8'hFF});
      send_message('{8'h00, 8'hFF});
      send_message('{8'hFF, 8'hFF, 8'hFF});
      send_message('{8'hFB, 8'hEF, 8'hBE});
      send_message('{8'h00, 8'h00, 8'h00, 8'h00});
      send_message('{8'hA5, 8'h5A, 8'hC3, 8'h3C, 8'h81});
   endtask

   // random messages, mostly short, a few long ones
   task automatic test_random_messages(input int num_bytes);
      logic [7:0] bytes[$];
      int         sent;
      int         len;
      int         i;
      sent = 0;
      while (sent < num_bytes) begin
         if ($urandom_range(9) == 0) begin
            len = $urandom_range(40, 10);
         end else begin
            len = $urandom_range(8, 1);
         end
         if (len > num_bytes - sent) begin
            len = num_bytes - sent;
         end
         bytes.delete();
         for (i = 0; i < len; i++) begin
            bytes = {bytes, 8'($urandom_range(255))};
         end
         send_message(bytes);
         sent = sent + len;
      end
   endtask

   always @(posedge clock) begin
      code_word_type want;
      if (!reset && pop && !empty) begin
         if (expected_chars.size() == 0) begin
            mismatches <= mismatches + 1;
            if (mismatches < MaxReports) begin
               $display("unexpected word: code %h run_end %b message_end %b",
                        rsp_code_char, rsp_run_end, rsp_message_end);
            end
         end else begin
            want = expected_chars.pop_front();
            if (rsp_code_char !== want.code || rsp_run_end !== want.run_end ||
                rsp_message_end !== want.msg_end) begin
               mismatches <= mismatches + 1;
               if (mismatches < MaxReports) begin
                  $display("mismatch: expected code %h run_end %b message_end %b, %s",
                           want.code, want.run_end, want.msg_end, "got");
                  $display("          actual   code %h run_end %b message_end %b",
                           rsp_code_char, rsp_run_end, rsp_message_end);
               end
            end
         end
      end
      pop <= ($urandom_range(99) >= recv_gap_pct);
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;
      send_gap_pct = 28;
      recv_gap_pct = 74;
      test_padding_cases();
      test_random_messages(104);
      send_gap_pct = 74;
      recv_gap_pct = 28;
      test_random_messages(104);
      send_gap_pct = 0;
      recv_gap_pct = 0;
      test_random_messages(104);
      push <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/b64se_pkg.sv
rtl/b64se_front.sv
rtl/b64se_queue.sv
rtl/b64se_back.sv
rtl/base64_stream_encoder.sv
dv/tb_base64_stream_encoder.sv
